// ----- design/fsa_pkg.sv -----
// Shared types, codes and constants for the fraction sum accumulator.
package fsa_pkg;

    localparam int WORD_W  = 32;
    localparam int WIDE_W  = 64;
    localparam int SHIFT_W = $clog2(WIDE_W);

    // Status codes of a result word.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_ZERO = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    // Largest quotient magnitudes that still fit a signed 32-bit result.
    localparam logic [WIDE_W-1:0] POS_LIMIT = WIDE_W'(64'h0000_0000_7FFF_FFFF);
    localparam logic [WIDE_W-1:0] NEG_LIMIT = WIDE_W'(64'h0000_0000_8000_0000);

    // Main sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_Q,
        S_MUL_D,
        S_SUM,
        S_CHECK,
        S_GCD,
        S_GCD_WAIT,
        S_DIVN,
        S_DIVN_WAIT,
        S_DIVD,
        S_DIVD_WAIT,
        S_FINISH
    } fsa_state_t;

    // Divider states.
    typedef enum logic [1:0] {
        D_IDLE,
        D_ALIGN,
        D_SUB
    } fsa_div_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
        logic [WIDE_W-1:0] divisor;
    } fsa_div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic              done;
        logic [WIDE_W-1:0] quotient;
        logic [WIDE_W-1:0] remainder;
    } fsa_div_rsp_t;

endpackage

// ----- design/fsa_if.sv -----
// Handshake channels for the input fraction word and the result word.
interface fsa_in_if import fsa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] add_numerator;
    logic signed [WORD_W-1:0] add_denominator;
    logic                     first;

    modport source (output valid, output add_numerator, output add_denominator,
                    output first, input ready);
    modport sink (input valid, input add_numerator, input add_denominator,
                  input first, output ready);
endinterface

interface fsa_out_if import fsa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] sum_numerator;
    logic signed [WORD_W-1:0] sum_denominator;
    logic [1:0]               status;

    modport source (output valid, output sum_numerator, output sum_denominator,
                    output status, input ready);
    modport sink (input valid, input sum_numerator, input sum_denominator,
                  input status, output ready);
endinterface

// ----- design/fsa_div.sv -----
// Shared 64-bit unsigned shift-subtract divider giving quotient and remainder.
module fsa_div import fsa_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  fsa_div_req_t req,
    output fsa_div_rsp_t rsp
);

    fsa_div_state_t      state_reg, state_next;
    logic [WIDE_W-1:0]   r_reg, r_next;
    logic [WIDE_W-1:0]   d_reg, d_next;
    logic [WIDE_W-1:0]   q_reg, q_next;
    logic [SHIFT_W-1:0]  k_reg, k_next;
    logic                done_reg, done_next;

    logic [WIDE_W-1:0]   d_dbl;
    logic                can_shift;
    logic [WIDE_W:0]     diff;
    logic                ge;

    // One compare or one compare-subtract per cycle.
    assign d_dbl     = {d_reg[WIDE_W-2:0], 1'b0};
    assign can_shift = !d_reg[WIDE_W-1] && (d_dbl <= r_reg) &&
                       (k_reg != SHIFT_W'(WIDE_W - 1));
    assign diff      = {1'b0, r_reg} - {1'b0, d_reg};
    assign ge        = !diff[WIDE_W];

    always_comb
    begin
        state_next = state_reg;
        r_next     = r_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    r_next     = req.dividend;
                    d_next     = req.divisor;
                    q_next     = '0;
                    k_next     = '0;
                    state_next = D_ALIGN;
                end
            end
            // Walk the divisor up under the dividend's leading bit.
            D_ALIGN:
            begin
                if (can_shift)
                begin
                    d_next = d_dbl;
                    k_next = k_reg + SHIFT_W'(1);
                end
                else
                begin
                    state_next = D_SUB;
                end
            end
            // Restoring step: one quotient bit, then walk the divisor back down.
            D_SUB:
            begin
                if (ge)
                begin
                    r_next = diff[WIDE_W-1:0];
                    q_next = {q_reg[WIDE_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_reg[WIDE_W-2:0], 1'b0};
                end
                if (k_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    d_next = {1'b0, d_reg[WIDE_W-1:1]};
                    k_next = k_reg - SHIFT_W'(1);
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        d_reg <= d_next;
        q_reg <= q_next;
        k_reg <= k_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

endmodule

// ----- design/fraction_sum_accumulator_unit.sv -----
// Running fraction accumulator: adds each input fraction and reduces by Euclid's GCD.
//
// The block holds a running sum that starts at 0/1 after reset; each input word adds
// add_numerator/add_denominator by cross-multiplication at 64 bits, reduces the sum by
// Euclid's remainder GCD with truncating (C-style) signs, stores it and returns it. A
// set first bit restarts from 0/1 before adding. Status 1 flags a zero denominator and
// status 2 an overflow of the 64-bit sum or of a reduced 32-bit part; in both cases the
// running sum is kept and returned unchanged. One item is processed at a time and the
// input is not ready until its result has been loaded into the output register. The
// time per item is set by one shared shift-subtract divider, whose work for a division
// grows with how many places the divisor is shifted up under the dividend (none when
// the dividend is the smaller). Euclid needs one division per remainder step, and two
// more divisions turn the sum into its reduced parts.
module fraction_sum_accumulator_unit import fsa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    fsa_in_if.sink    add_in,
    fsa_out_if.source sum_out
);

    fsa_state_t               state_reg, state_next;
    logic signed [WORD_W-1:0] run_num_reg, run_num_next;
    logic signed [WORD_W-1:0] run_den_reg, run_den_next;
    logic                     out_valid_reg, out_valid_next;

    logic signed [WORD_W-1:0] op_n_reg, op_n_next;
    logic signed [WORD_W-1:0] op_d_reg, op_d_next;
    logic signed [WORD_W-1:0] an_reg, an_next;
    logic signed [WORD_W-1:0] ad_reg, ad_next;
    logic [WIDE_W-1:0]        p_reg, p_next;
    logic [WIDE_W-1:0]        q_reg, q_next;
    logic [WIDE_W-1:0]        den_reg, den_next;
    logic [WIDE_W-1:0]        num_reg, num_next;
    logic                     ovf_reg, ovf_next;
    logic [WIDE_W-1:0]        a_reg, a_next;
    logic [WIDE_W-1:0]        b_reg, b_next;
    logic [WIDE_W-1:0]        num_mag_reg, num_mag_next;
    logic [WIDE_W-1:0]        den_mag_reg, den_mag_next;
    logic                     num_neg_reg, num_neg_next;
    logic                     den_neg_reg, den_neg_next;
    logic                     odd_reg, odd_next;
    logic                     g_neg_reg, g_neg_next;
    logic [WORD_W-1:0]        n32_reg, n32_next;
    logic [WORD_W-1:0]        d32_reg, d32_next;
    logic [1:0]               status_reg, status_next;
    logic [WORD_W-1:0]        out_num_reg, out_num_next;
    logic [WORD_W-1:0]        out_den_reg, out_den_next;
    logic [1:0]               out_status_reg, out_status_next;

    logic signed [WORD_W-1:0] mul_a;
    logic signed [WORD_W-1:0] mul_b;
    logic signed [WIDE_W-1:0] product;
    logic [WIDE_W:0]          sum_wide;
    logic                     accept;
    logic                     out_free;
    logic                     q_neg;
    logic                     q_fits;
    logic [WORD_W-1:0]        q_signed;
    fsa_div_req_t             div_req;
    fsa_div_rsp_t             div_rsp;

    // Two's complement magnitude of a 64-bit value.
    function automatic logic [WIDE_W-1:0] mag64(input logic [WIDE_W-1:0] v);
        mag64 = v[WIDE_W-1] ? (~v + WIDE_W'(1)) : v;
    endfunction

    fsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The one multiplier is shared by the three cross products.
    always_comb
    begin
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = op_n_reg;
                mul_b = ad_reg;
            end
            S_MUL_Q:
            begin
                mul_a = op_d_reg;
                mul_b = an_reg;
            end
            default:
            begin
                mul_a = op_d_reg;
                mul_b = ad_reg;
            end
        endcase
    end

    assign product  = mul_a * mul_b;
    assign sum_wide = {p_reg[WIDE_W-1], p_reg} + {q_reg[WIDE_W-1], q_reg};
    assign accept   = add_in.valid && add_in.ready;
    assign out_free = !out_valid_reg || sum_out.ready;

    // Sign and range of a reduced part coming out of the divider.
    assign q_neg    = (state_reg == S_DIVN_WAIT) ? (num_neg_reg ^ g_neg_reg)
                                                  : (den_neg_reg ^ g_neg_reg);
    assign q_fits   = q_neg ? (div_rsp.quotient <= NEG_LIMIT)
                            : (div_rsp.quotient <= POS_LIMIT);
    assign q_signed = q_neg ? (~div_rsp.quotient[WORD_W-1:0] + WORD_W'(1))
                            : div_rsp.quotient[WORD_W-1:0];

    // Sequencer: next state, datapath loads and divider requests.
    always_comb
    begin
        state_next      = state_reg;
        run_num_next    = run_num_reg;
        run_den_next    = run_den_reg;
        out_valid_next  = out_valid_reg;
        op_n_next       = op_n_reg;
        op_d_next       = op_d_reg;
        an_next         = an_reg;
        ad_next         = ad_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        ovf_next        = ovf_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        num_mag_next    = num_mag_reg;
        den_mag_next    = den_mag_reg;
        num_neg_next    = num_neg_reg;
        den_neg_next    = den_neg_reg;
        odd_next        = odd_reg;
        g_neg_next      = g_neg_reg;
        n32_next        = n32_reg;
        d32_next        = d32_reg;
        status_next     = status_reg;
        out_num_next    = out_num_reg;
        out_den_next    = out_den_reg;
        out_status_next = out_status_reg;
        div_req.start    = 1'b0;
        div_req.dividend = a_reg;
        div_req.divisor  = b_reg;

        // The output word leaves when the sink takes it.
        if (sum_out.valid && sum_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_n_next   = add_in.first ? '0 : run_num_reg;
                    op_d_next   = add_in.first ? WORD_W'(1) : run_den_reg;
                    an_next     = add_in.add_numerator;
                    ad_next     = add_in.add_denominator;
                    status_next = STATUS_OK;
                    state_next  = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                p_next     = product;
                state_next = S_MUL_Q;
            end
            S_MUL_Q:
            begin
                q_next     = product;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                den_next   = product;
                state_next = S_SUM;
            end
            // Wide add with a 65th bit to catch a sum past the 64-bit range.
            S_SUM:
            begin
                num_next   = sum_wide[WIDE_W-1:0];
                ovf_next   = sum_wide[WIDE_W] != sum_wide[WIDE_W-1];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                num_mag_next = mag64(num_reg);
                den_mag_next = mag64(den_reg);
                num_neg_next = num_reg[WIDE_W-1];
                den_neg_next = den_reg[WIDE_W-1];
                a_next       = mag64(num_reg);
                b_next       = mag64(den_reg);
                odd_next     = 1'b0;
                if (ovf_reg)
                begin
                    status_next = STATUS_OVF;
                    state_next  = S_FINISH;
                end
                else if (den_reg == '0)
                begin
                    status_next = STATUS_ZERO;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            // Euclid on magnitudes; remainders alternate between the signs of the
            // sum and of the denominator, so the step count gives the GCD's sign.
            S_GCD:
            begin
                if (b_reg == '0)
                begin
                    g_neg_next = odd_reg ? den_neg_reg : num_neg_reg;
                    state_next = S_DIVN;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_GCD_WAIT;
                end
            end
            S_GCD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    a_next     = b_reg;
                    b_next     = div_rsp.remainder;
                    odd_next   = !odd_reg;
                    state_next = S_GCD;
                end
            end
            S_DIVN:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_mag_reg;
                div_req.divisor  = a_reg;
                state_next       = S_DIVN_WAIT;
            end
            S_DIVN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    n32_next = q_signed;
                    if (!q_fits)
                    begin
                        status_next = STATUS_OVF;
                    end
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = den_mag_reg;
                div_req.divisor  = a_reg;
                state_next       = S_DIVD_WAIT;
            end
            S_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    d32_next = q_signed;
                    if (!q_fits)
                    begin
                        status_next = STATUS_OVF;
                    end
                    state_next = S_FINISH;
                end
            end
            // Commit the running sum on success and load the output word.
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == STATUS_OK)
                    begin
                        run_num_next = n32_reg;
                        run_den_next = d32_reg;
                        out_num_next = n32_reg;
                        out_den_next = d32_reg;
                    end
                    else
                    begin
                        out_num_next = run_num_reg;
                        out_den_next = run_den_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            run_num_reg   <= '0;
            run_den_reg   <= WORD_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_num_reg   <= run_num_next;
            run_den_reg   <= run_den_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_n_reg       <= op_n_next;
        op_d_reg       <= op_d_next;
        an_reg         <= an_next;
        ad_reg         <= ad_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        den_reg        <= den_next;
        num_reg        <= num_next;
        ovf_reg        <= ovf_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        num_mag_reg    <= num_mag_next;
        den_mag_reg    <= den_mag_next;
        num_neg_reg    <= num_neg_next;
        den_neg_reg    <= den_neg_next;
        odd_reg        <= odd_next;
        g_neg_reg      <= g_neg_next;
        n32_reg        <= n32_next;
        d32_reg        <= d32_next;
        status_reg     <= status_next;
        out_num_reg    <= out_num_next;
        out_den_reg    <= out_den_next;
        out_status_reg <= out_status_next;
    end

    assign add_in.ready            = (state_reg == S_IDLE);
    assign sum_out.valid           = out_valid_reg;
    assign sum_out.sum_numerator   = out_num_reg;
    assign sum_out.sum_denominator = out_den_reg;
    assign sum_out.status          = out_status_reg;

    // A new result word only appears out of the commit state.
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside the commit state");

    // The stored running denominator is never zero.
    a_run_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_den_reg != '0)
        else $error("running denominator became zero");

    // Only the three defined status codes are ever shown.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        sum_out.valid |-> (sum_out.status == STATUS_OK ||
                           sum_out.status == STATUS_ZERO ||
                           sum_out.status == STATUS_OVF))
        else $error("undefined status code on the output");

    // An accepted word starts the multiply sequence at once.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL_P)
        else $error("accepted word did not start the multiply sequence");

endmodule

// ----- verif/fraction_sum_accumulator_unit_test.sv -----
// Self-checking testbench for the running fraction accumulator with GCD reduction.
`timescale 1ns / 1ps

module fraction_sum_accumulator_unit_test;
    import fsa_pkg::*;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
    localparam int  RANDOM_WORDS = 1930;
    localparam int  HOLD_CYCLES  = 2500;
    localparam int  SETTLE       = 1100;
    localparam longint CYCLE_LIMIT = 10_000_000;

    // One input word, with the idle cycles that precede it on the wire.
    typedef struct {
        logic signed [WORD_W-1:0] num;
        logic signed [WORD_W-1:0] den;
        logic                     first;
        int                       pause;
        bit                       drain;
    } fraction_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] num;
        logic signed [WORD_W-1:0] den;
        logic [1:0]               status;
    } sum_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fsa_in_if  add_ch();
    fsa_out_if sum_ch();

    fraction_sum_accumulator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .add_in  (add_ch),
        .sum_out (sum_ch)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    fraction_t pending_words[$];
    sum_t      sum_expect[$];
    fraction_t cur;
    logic signed [WORD_W-1:0] run_num;
    logic signed [WORD_W-1:0] run_den;
    int     gap_left;
    bit     launch;
    int     words_sent;
    int     results_seen;
    int     rx_gap;
    bit     rx_next;
    int     errors;
    int     drains;
    int     holds_done;
    int     hold_cnt;
    int     status_count [0:3];
    longint cycle_count;
    sum_t   want;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        longint unsigned u;
        u = v;
        return (v < 0) ? -u : u;
    endfunction

    // Truncating quotient; returns 0 when it does not fit a signed 32-bit word.
    function automatic bit quotient32(input longint a, input longint b,
                                      output logic signed [WORD_W-1:0] q);
        longint unsigned m;
        m = magnitude(a) / magnitude(b);
        q = '0;
        if ((a < 0) != (b < 0))
        begin
            if (m > 64'h8000_0000)
                return 1'b0;
            m = -m;
            q = m[WORD_W-1:0];
        end
        else
        begin
            if (m > 64'h7FFF_FFFF)
                return 1'b0;
            q = m[WORD_W-1:0];
        end
        return 1'b1;
    endfunction

    // Adds one word to the running sum, reduces it and returns the expected result.
    function automatic sum_t add_fraction(input fraction_t w);
        longint an, ad, rn, rd, p, q, den, num, i, j, z;
        logic signed [WORD_W-1:0] n32, d32;
        logic [1:0] st;
        sum_t r;
        an = w.num;
        ad = w.den;
        if (w.first)
        begin
            rn = 0;
            rd = 1;
        end
        else
        begin
            rn = run_num;
            rd = run_den;
        end
        p = rn * ad;
        q = rd * an;
        den = rd * ad;
        st = STATUS_OK;
        if ((p > 0 && q > I64_MAX - p) || (p < 0 && q < I64_MIN - p))
            st = STATUS_OVF;
        else if (den == 0)
            st = STATUS_ZERO;
        else
        begin
            num = p + q;
            i = num;
            j = den;
            // Euclid with truncating remainder: the remainder keeps the dividend's sign.
            while (j != 0)
            begin
                z = longint'(magnitude(i) % magnitude(j));
                if (i < 0)
                    z = -z;
                i = j;
                j = z;
            end
            if (i == 0)
                st = STATUS_ZERO;
            else if (!quotient32(num, i, n32) || !quotient32(den, i, d32))
                st = STATUS_OVF;
            else
            begin
                run_num = n32;
                run_den = d32;
            end
        end
        status_count[st]++;
        r.num = run_num;
        r.den = run_den;
        r.status = st;
        return r;
    endfunction

    task automatic queue_word(input logic signed [WORD_W-1:0] n,
                              input logic signed [WORD_W-1:0] d,
                              input logic f, input int pause, input bit drain);
        fraction_t w;
        w.num = n;
        w.den = d;
        w.first = f;
        w.pause = pause;
        w.drain = drain;
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch at result %0d: %s is %0d, expected %0d",
                 results_seen, what, got, exp);
        errors++;
    endtask

    // Driver: offers pending words, holding each until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_ch.valid <= 1'b0;
            add_ch.add_numerator <= '0;
            add_ch.add_denominator <= '0;
            add_ch.first <= 1'b0;
            gap_left = -1;
        end
        else
        begin
            if (add_ch.valid && add_ch.ready)
            begin
                sum_expect.push_back(add_fraction(cur));
                words_sent++;
            end
            if (!(add_ch.valid && !add_ch.ready))
            begin
                launch = 1'b0;
                // A draining word waits until every result in flight has come back.
                if (pending_words.size() != 0 &&
                    !(pending_words[0].drain && sum_expect.size() != 0))
                begin
                    if (gap_left < 0)
                        gap_left = pending_words[0].pause;
                    if (gap_left == 0)
                        launch = 1'b1;
                    else
                        gap_left--;
                end
                if (launch)
                begin
                    cur = pending_words.pop_front();
                    gap_left = -1;
                    add_ch.valid <= 1'b1;
                    add_ch.add_numerator <= cur.num;
                    add_ch.add_denominator <= cur.den;
                    add_ch.first <= cur.first;
                end
                else
                    add_ch.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-offs, counted here so the block backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            holds_done <= 0;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 300 : 1200))
        begin
            hold_cnt <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Monitor: checks each result word against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_ch.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            rx_next = 1'b1;
            if (sum_ch.valid && sum_ch.ready)
            begin
                if (sum_expect.size() == 0)
                    report_mismatch("result with nothing pending, sum_numerator",
                                    sum_ch.sum_numerator, 0);
                else
                begin
                    want = sum_expect.pop_front();
                    if (sum_ch.sum_numerator !== want.num)
                        report_mismatch("sum_numerator", sum_ch.sum_numerator, want.num);
                    if (sum_ch.sum_denominator !== want.den)
                        report_mismatch("sum_denominator", sum_ch.sum_denominator, want.den);
                    if (sum_ch.status !== want.status)
                        report_mismatch("status", sum_ch.status, want.status);
                end
                results_seen++;
                // Every third stretch of 128 results runs with the receiver always ready.
                rx_gap = ((results_seen / 128) % 3 == 1) ? 0 : pick_gap();
            end
            else if (rx_gap > 0)
                rx_gap--;
            if (rx_gap > 0 || hold_cnt != 0)
                rx_next = 1'b0;
            sum_ch.ready <= rx_next;
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run exceeded %0d cycles", CYCLE_LIMIT);
        $display("** fraction_sum_accumulator_unit: FAILED **");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        int r;
        int n;
        int d;
        int pause;
        logic signed [WORD_W-1:0] ext_num [5];
        logic signed [WORD_W-1:0] ext_den [4];
        add_ch.valid = 1'b0;
        add_ch.add_numerator = '0;
        add_ch.add_denominator = '0;
        add_ch.first = 1'b0;
        sum_ch.ready = 1'b0;
        run_num = 0;
        run_den = 1;
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        drains = 0;
        foreach (status_count[k])
            status_count[k] = 0;
        ext_num = '{W_MIN, W_MAX, -1, 0, 1};
        ext_den = '{W_MIN, W_MAX, -1, 1};

        // Directed words: simple sums, zero numerator, zero denominators, the
        // extremes of both fields, sum and reduced-part overflow, negative signs.
        queue_word(1, 2, 1'b1, 0, 1'b0);
        queue_word(1, 3, 1'b0, 0, 1'b0);
        queue_word(-5, 6, 1'b0, 2, 1'b0);
        queue_word(0, 0, 1'b0, 0, 1'b0);
        queue_word(7, 0, 1'b1, 0, 1'b0);
        queue_word(W_MAX, -1, 1'b1, 0, 1'b0);
        queue_word(W_MIN, -1, 1'b1, 1, 1'b0);
        queue_word(W_MIN, 1, 1'b1, 0, 1'b0);
        queue_word(W_MIN, 1, 1'b0, 0, 1'b0);
        queue_word(0, W_MIN, 1'b1, 0, 1'b0);
        queue_word(W_MAX, 1, 1'b1, 0, 1'b0);
        queue_word(W_MAX, 1, 1'b0, 3, 1'b0);
        queue_word(1, W_MAX, 1'b1, 0, 1'b0);
        queue_word(1, W_MAX - 1, 1'b0, 0, 1'b0);
        queue_word(1, W_MIN, 1'b1, 0, 1'b0);
        queue_word(1, W_MIN, 1'b0, 0, 1'b0);
        queue_word(-1, 1, 1'b1, 0, 1'b0);
        queue_word(0, -1, 1'b0, 0, 1'b0);
        queue_word(-1, -1, 1'b1, 0, 1'b0);
        queue_word(W_MAX, W_MAX, 1'b1, 0, 1'b0);
        queue_word(W_MIN, W_MIN, 1'b0, 0, 1'b0);
        queue_word(3, -6, 1'b0, 0, 1'b1);

        // Random words: mostly small fractions that keep the sum in range, with
        // restarts, plus full-width values, zero denominators and extremes.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                n = int'($urandom_range(0, 200)) - 100;
                d = $urandom_range(1, 60);
            end
            else if (r < 75)
            begin
                n = int'($urandom_range(0, 65535)) - 32768;
                d = $urandom_range(1, 32768);
            end
            else if (r < 87)
            begin
                n = $urandom;
                d = $urandom;
            end
            else if (r < 92)
            begin
                n = $urandom;
                d = 0;
            end
            else
            begin
                n = ext_num[$urandom_range(0, 4)];
                d = ext_den[$urandom_range(0, 3)];
            end
            if (r < 75 && $urandom_range(0, 1))
                d = -d;
            pause = ((i / 150) % 3 == 2) ? 0 : pick_gap();
            queue_word(n, d, $urandom_range(0, 9) == 0, pause, i == 1000 || i == 1600);
        end
        foreach (pending_words[k])
            if (pending_words[k].drain)
                drains++;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || add_ch.valid === 1'b1 || sum_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d words, checked %0d results: %0d ok, %0d zero denominator, %0d overflow.",
                 words_sent, results_seen, status_count[STATUS_OK],
                 status_count[STATUS_ZERO], status_count[STATUS_OVF]);
        $display("Receiver held off %0d times for %0d cycles; sender drained the block %0d times.",
                 holds_done, HOLD_CYCLES, drains);
        if (errors == 0)
            $display("** fraction_sum_accumulator_unit: PASSED **");
        else
            $display("** fraction_sum_accumulator_unit: FAILED **");
        $finish;
    end

endmodule
